@@ design/assert_macros.svh @@
// Assertion macros shared by the RTL of the bitmap region fill block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/brf_pkg.sv @@
// Shared constants, types and helper functions of the bitmap region fill block.
// Depends on nothing; used by brf_ctrl and bitmap_region_fill.
package brf_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int CELL_BITS = 8;
    localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SIDE_W    = 7;
    localparam int COORD_W   = 6;
    localparam int RAD_W     = 5;
    localparam int SQ_W      = 2 * RAD_W;

    localparam logic [1:0] CMD_READ        = 2'd0;
    localparam logic [1:0] CMD_WRITE       = 2'd1;
    localparam logic [1:0] CMD_FILL_SQUARE = 2'd2;
    localparam logic [1:0] CMD_FILL_CIRCLE = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Result status codes.
    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [7:0]         fill_value;
        logic [RAD_W-1:0]   radius;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
        logic [1:0]         command;
    } cmd_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_value;
    } result_t;

    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [ADDR_W-1:0]    addr;
        logic [CELL_BITS-1:0] wdata;
    } ram_req_t;

    typedef struct packed {
        logic clearing;
        logic res_pending;
    } ctrl_stat_t;

    // Square of a radius-sized distance.
    function automatic logic [SQ_W-1:0] sq(input logic [RAD_W-1:0] v);
        return SQ_W'(v) * SQ_W'(v);
    endfunction

endpackage

@@ design/brf_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
// Depends on nothing.
module brf_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ design/brf_ctrl.sv @@
// Command sequencer: clearing pass, bounds checks, cell access and fill raster.
// Depends on brf_pkg; drives the cell RAM through a ram_req_t request.
module brf_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  brf_pkg::cmd_t               cmd,
    input  logic [brf_pkg::SIDE_W-1:0]  width_eff,
    input  logic [brf_pkg::SIDE_W-1:0]  height_eff,
    output brf_pkg::ram_req_t           ram_req,
    input  logic [brf_pkg::CELL_BITS-1:0] ram_rdata,
    output logic                        res_valid,
    input  logic                        res_take,
    output brf_pkg::result_t            res,
    output brf_pkg::ctrl_stat_t         stat
);
    import brf_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    cmd_t               cmd_reg, cmd_next;
    logic [COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [COORD_W-1:0] x_start_reg, x_start_next, x_end_reg, x_end_next;
    logic [COORD_W-1:0] y_end_reg, y_end_next;
    logic [ADDR_W-1:0]  row_base_reg, row_base_next;
    logic [SQ_W-1:0]    dy2_reg, dy2_next, rr_reg, rr_next;
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    logic [SIDE_W-1:0]       x_hi, y_hi;
    logic                    cell_ok, shape_ok, is_fill;
    logic [COORD_W-1:0]      y_sel, y_inc;
    logic [ADDR_W+SIDE_W-1:0] prod;
    logic [ADDR_W-1:0]       row_addr;
    logic [COORD_W-1:0]      dx_full, dy_full;
    logic [SQ_W:0]           dist2;
    logic                    covered;

    // Bounds and row address of the held command.
    always_comb begin
        x_hi     = SIDE_W'(cmd_reg.pos_x) + SIDE_W'(cmd_reg.radius);
        y_hi     = SIDE_W'(cmd_reg.pos_y) + SIDE_W'(cmd_reg.radius);
        cell_ok  = (SIDE_W'(cmd_reg.pos_x) < width_eff) && (SIDE_W'(cmd_reg.pos_y) < height_eff);
        shape_ok = (cmd_reg.pos_x >= COORD_W'(cmd_reg.radius))
                && (cmd_reg.pos_y >= COORD_W'(cmd_reg.radius))
                && (x_hi < width_eff) && (y_hi < height_eff);
        is_fill  = cmd_reg.command[1];
        y_sel    = is_fill ? cmd_reg.pos_y - COORD_W'(cmd_reg.radius) : cmd_reg.pos_y;
        prod     = (ADDR_W+SIDE_W)'(y_sel) * (ADDR_W+SIDE_W)'(width_eff);
        row_addr = prod[ADDR_W-1:0];
    end

    // Coverage test of the raster cell.
    always_comb begin
        dx_full = (x_reg >= cmd_reg.pos_x) ? x_reg - cmd_reg.pos_x : cmd_reg.pos_x - x_reg;
        y_inc   = y_reg + COORD_W'(1);
        dy_full = (y_inc >= cmd_reg.pos_y) ? y_inc - cmd_reg.pos_y : cmd_reg.pos_y - y_inc;
        dist2   = (SQ_W+1)'(sq(dx_full[RAD_W-1:0])) + (SQ_W+1)'(dy2_reg);
        covered = (cmd_reg.command == CMD_FILL_SQUARE) || (dist2 <= (SQ_W+1)'(rr_reg));
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x_start_next   = x_start_reg;
        x_end_next     = x_end_reg;
        y_end_next     = y_end_reg;
        row_base_next  = row_base_reg;
        dy2_next       = dy2_reg;
        rr_next        = rr_reg;
        res_valid_next = res_valid_reg && !res_take;
        res_next       = res_reg;
        ram_req        = '0;
        cmd_ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_req.en   = 1'b1;
                ram_req.we   = 1'b1;
                ram_req.addr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd_ready = !res_valid_reg;
                if (cmd_valid && !res_valid_reg) begin
                    cmd_next   = cmd;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_next.read_value = '0;
                res_next.status     = STATUS_DONE;
                state_next          = ST_IDLE;
                unique case (cmd_reg.command) inside
                    CMD_READ: begin
                        if (cell_ok) begin
                            ram_req.en   = 1'b1;
                            ram_req.addr = row_addr + ADDR_W'(cmd_reg.pos_x);
                            state_next   = ST_READ;
                        end else begin
                            res_next.status = STATUS_REJECTED;
                            res_valid_next  = 1'b1;
                        end
                    end
                    CMD_WRITE: begin
                        res_valid_next = 1'b1;
                        if (cell_ok) begin
                            ram_req.en    = 1'b1;
                            ram_req.we    = 1'b1;
                            ram_req.addr  = row_addr + ADDR_W'(cmd_reg.pos_x);
                            ram_req.wdata = cmd_reg.fill_value[CELL_BITS-1:0];
                        end else begin
                            res_next.status = STATUS_REJECTED;
                        end
                    end
                    CMD_FILL_SQUARE, CMD_FILL_CIRCLE: begin
                        if (shape_ok) begin
                            x_next        = cmd_reg.pos_x - COORD_W'(cmd_reg.radius);
                            x_start_next  = cmd_reg.pos_x - COORD_W'(cmd_reg.radius);
                            x_end_next    = x_hi[COORD_W-1:0];
                            y_next        = y_sel;
                            y_end_next    = y_hi[COORD_W-1:0];
                            row_base_next = row_addr;
                            rr_next       = sq(cmd_reg.radius);
                            dy2_next      = sq(cmd_reg.radius);
                            state_next    = ST_FILL;
                        end else begin
                            res_next.status = STATUS_REJECTED;
                            res_valid_next  = 1'b1;
                        end
                    end
                    default: begin
                        res_valid_next = 1'b1;
                    end
                endcase
            end
            ST_READ: begin
                res_next.read_value = 8'(ram_rdata);
                res_next.status     = STATUS_DONE;
                res_valid_next      = 1'b1;
                state_next          = ST_IDLE;
            end
            ST_FILL: begin
                ram_req.en    = covered;
                ram_req.we    = 1'b1;
                ram_req.addr  = row_base_reg + ADDR_W'(x_reg);
                ram_req.wdata = cmd_reg.fill_value[CELL_BITS-1:0];
                x_next        = x_reg + COORD_W'(1);
                if (x_reg == x_end_reg) begin
                    if (y_reg == y_end_reg) begin
                        res_next.read_value = '0;
                        res_next.status     = STATUS_DONE;
                        res_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end else begin
                        x_next        = x_start_reg;
                        y_next        = y_inc;
                        row_base_next = row_base_reg + ADDR_W'(width_eff);
                        dy2_next      = sq(dy_full[RAD_W-1:0]);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        x_start_reg  <= x_start_next;
        x_end_reg    <= x_end_next;
        y_end_reg    <= y_end_next;
        row_base_reg <= row_base_next;
        dy2_reg      <= dy2_next;
        rr_reg       <= rr_next;
        res_reg      <= res_next;
    end

    assign res_valid        = res_valid_reg;
    assign res              = res_reg;
    assign stat.clearing    = (state_reg == ST_CLEAR);
    assign stat.res_pending = res_valid_reg;

endmodule

@@ design/bitmap_region_fill.sv @@
// Top level of the bitmap region fill block: size registers, sequencer, cell RAM, result register.
// Depends on brf_pkg, brf_ram, brf_ctrl and assert_macros.svh.
//
// A bitmap of up to 64 by 64 byte cells, held in one single-port synchronous RAM and addressed
// row-major at y*width+x. After reset the block runs a clearing pass over every cell, one cell per
// cycle, during which s_tready stays low; configuration writes are taken throughout. Commands
// are handled one at a time. A read passes through accept, address and bounds check, and RAM
// read before its result; a write or a rejected command through accept and check; and a fill
// through accept and check and then a raster that visits every cell of the bounding square with
// one RAM write port. The result then sits in an output register, so the next command is taken
// while the previous result waits for the downstream side.
`include "assert_macros.svh"

module bitmap_region_fill (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: index 0 map_width, index 1 map_height.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_wdata,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // command[1:0], pos_x[7:2], pos_y[13:8], radius[18:14],
                                  // fill_value[26:19], zero above
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_value[7:0], status[8], zero above
);
    import brf_pkg::*;

    logic [SIDE_W-1:0]    map_width_reg, map_height_reg;
    logic [SIDE_W-1:0]    width_eff, height_eff;
    cmd_t                 cmd;
    ram_req_t             ram_req;
    logic [CELL_BITS-1:0] ram_rdata;
    logic                 res_valid, res_take;
    result_t              res;
    ctrl_stat_t           stat;
    logic                 m_valid_reg;
    result_t              m_data_reg;

    // Size registers; a value above the physical side is used as the full side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg  <= SIDE_W'(MAX_SIDE);
            map_height_reg <= SIDE_W'(MAX_SIDE);
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_WIDTH) begin
                map_width_reg <= cfg_wdata;
            end else begin
                map_height_reg <= cfg_wdata;
            end
        end
    end

    assign width_eff  = (map_width_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : map_width_reg;
    assign height_eff = (map_height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : map_height_reg;

    assign cmd = s_tdata[$bits(cmd_t)-1:0];

    brf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (s_tvalid),
        .cmd_ready  (s_tready),
        .cmd        (cmd),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .stat       (stat)
    );

    brf_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (CELL_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // The output register takes a finished result whenever it is empty or being emptied.
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    // No command is taken during the clearing pass.
    `ASSERT_IMPLIES(a_no_accept_clear, aclk, aresetn, stat.clearing, !s_tready)
    // A command is taken only when the previous result has left the sequencer.
    `ASSERT_IMPLIES(a_accept_slot_free, aclk, aresetn, s_tready, !stat.res_pending)
    // A pending result blocked by a full output register is kept.
    `ASSERT_NEXT(a_result_held, aclk, aresetn, res_valid && m_valid_reg && !m_tready,
                 res_valid && $stable(res))
    // A rejected command never carries read data.
    `ASSERT_IMPLIES(a_reject_zero, aclk, aresetn, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'd0)

endmodule
